### design/fpvn_pkg.sv
package fpvn_pkg;

  // Fraction bits of the fixed-point format, inputs and results alike
  localparam int FracBits  = 16;
  localparam int HalfFrac  = FracBits / 2;

  localparam int CompW     = 32;
  localparam int NumComp   = 3;
  // A square of a 32-bit signed value is at most 2^62
  localparam int ProdW     = 63;
  // Three truncated squares stay below 2^(64 - FracBits)
  localparam int SumW      = 64 - FracBits;
  localparam int RootSteps = (SumW + 1) / 2;
  localparam int LenW      = RootSteps + HalfFrac;
  localparam int DivW      = CompW + FracBits;
  localparam int CntW      = $clog2(DivW + 1);

  // Largest power of four that a squared length can reach
  localparam logic [SumW-1:0] ProbeStart = SumW'(1) << (2 * (RootSteps - 1));

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StRoot,
    StDivInit,
    StDiv,
    StFinish
  } fpvn_state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] mul_sel;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } fpvn_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic out_free;
  } fpvn_sts_t;

endpackage

### design/fpvn_div_lane.sv
module fpvn_div_lane (
  input  logic                        clk_i,
  input  logic                        init_i,
  input  logic                        step_i,
  input  logic signed [31:0]          comp_i,
  input  logic [fpvn_pkg::LenW-1:0]   divisor_i,
  output logic signed [31:0]          quo_o
);
  import fpvn_pkg::*;

  logic [DivW-1:0]  dvd_q;
  logic [LenW-1:0]  rem_q;
  logic [CompW-1:0] quo_q;
  logic             neg_q;
  logic [CompW-1:0] mag;
  logic [LenW:0]    trial;
  logic [LenW:0]    diff;
  logic             ge;

  // Magnitude of the most negative value still fits as unsigned
  assign mag   = comp_i[CompW-1] ? (~comp_i + CompW'(1)) : comp_i;
  assign trial = {rem_q, dvd_q[DivW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      dvd_q <= {mag, {FracBits{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= comp_i[CompW-1];
    end else if (step_i) begin
      rem_q <= ge ? diff[LenW-1:0] : trial[LenW-1:0];
      quo_q <= {quo_q[CompW-2:0], ge};
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
    end
  end

  // Truncation toward zero: divide magnitudes, then restore the sign
  assign quo_o = neg_q ? (~quo_q + CompW'(1)) : quo_q;

endmodule

### design/fpvn_datapath.sv
module fpvn_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpvn_pkg::fpvn_cmd_t  cmd_i,
  output fpvn_pkg::fpvn_sts_t  sts_o,
  input  logic signed [31:0]   vec_x_i,
  input  logic signed [31:0]   vec_y_i,
  input  logic signed [31:0]   vec_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   unit_x_o,
  output logic signed [31:0]   unit_y_o,
  output logic signed [31:0]   unit_z_o,
  output logic                 was_zero_o
);
  import fpvn_pkg::*;

  logic signed [CompW-1:0] comp_q [NumComp];
  logic signed [CompW-1:0] comp_sel;
  logic signed [63:0]      prod_full;
  logic [ProdW-1:0]        prod_q;
  logic [SumW-1:0]         sum_q;

  logic [SumW-1:0]         rt_rem_q;
  logic [SumW-1:0]         rt_acc_q;
  logic [SumW-1:0]         rt_probe_q;
  logic [SumW:0]           rt_trial;
  logic                    rt_ge;

  logic [LenW-1:0]         len_q;
  logic signed [CompW-1:0] quo [NumComp];

  logic                    out_valid_q;
  logic signed [CompW-1:0] unit_q [NumComp];
  logic                    was_zero_q;

  // Squares, one component a cycle
  assign comp_sel  = comp_q[cmd_i.mul_sel];
  assign prod_full = comp_sel * comp_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      comp_q[0] <= vec_x_i;
      comp_q[1] <= vec_y_i;
      comp_q[2] <= vec_z_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (cmd_i.acc_en) begin
      sum_q <= sum_q + {1'b0, prod_q[ProdW-1:FracBits]};
    end
  end

  // Bit-by-bit square root, one result bit a cycle
  assign rt_trial = {1'b0, rt_acc_q} + {1'b0, rt_probe_q};
  assign rt_ge    = {1'b0, rt_rem_q} >= rt_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rt_rem_q   <= sum_q;
      rt_acc_q   <= '0;
      rt_probe_q <= ProbeStart;
    end else if (cmd_i.root_step) begin
      if (rt_ge) begin
        rt_rem_q <= rt_rem_q - rt_trial[SumW-1:0];
        rt_acc_q <= (rt_acc_q >> 1) + rt_probe_q;
      end else begin
        rt_acc_q <= rt_acc_q >> 1;
      end
      rt_probe_q <= rt_probe_q >> 2;
    end
    if (cmd_i.div_init) begin
      len_q <= {rt_acc_q[RootSteps-1:0], {HalfFrac{1'b0}}};
    end
  end

  for (genvar g = 0; g < NumComp; g++) begin : g_lane
    fpvn_div_lane u_lane (
      .clk_i     (clk_i),
      .init_i    (cmd_i.div_init),
      .step_i    (cmd_i.div_step),
      .comp_i    (comp_q[g]),
      .divisor_i (len_q),
      .quo_o     (quo[g])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < NumComp; i++) begin
        unit_q[i] <= sts_o.sum_zero ? '0 : quo[i];
      end
      was_zero_q <= sts_o.sum_zero;
    end
  end

  assign sts_o.sum_zero = (sum_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign unit_x_o    = unit_q[0];
  assign unit_y_o    = unit_q[1];
  assign unit_z_o    = unit_q[2];
  assign was_zero_o  = was_zero_q;

endmodule

### design/fpvn_ctrl.sv
module fpvn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fpvn_pkg::fpvn_sts_t  sts_i,
  output fpvn_pkg::fpvn_cmd_t  cmd_o
);
  import fpvn_pkg::*;

  fpvn_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CntW'(1);
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_valid_i) state_d = StMul;
      end
      StMul: begin
        if (cnt_q == CntW'(NumComp)) state_d = StCheck;
      end
      StCheck: begin
        cnt_d   = '0;
        state_d = sts_i.sum_zero ? StFinish : StRoot;
      end
      StRoot: begin
        if (cnt_q == CntW'(RootSteps - 1)) state_d = StDivInit;
      end
      StDivInit: begin
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (cnt_q == CntW'(DivW - 1)) state_d = StFinish;
      end
      StFinish: begin
        cnt_d = '0;
        if (sts_i.out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.mul_sel = cnt_q[1:0];
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StMul: begin
        cmd_o.mul_en = (cnt_q < CntW'(NumComp));
        cmd_o.acc_en = (cnt_q != '0);
      end
      StCheck:   cmd_o.root_init = !sts_i.sum_zero;
      StRoot:    cmd_o.root_step = 1'b1;
      StDivInit: cmd_o.div_init  = 1'b1;
      StDiv:     cmd_o.div_step  = 1'b1;
      StFinish:  cmd_o.out_load  = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### design/fixed_point_vec3_normalize.sv
// Fixed-point 3-vector normaliser. A beat on the input carries a signed
// vector with FracBits fraction bits (16 by default); the result beat carries
// the vector scaled to unit length in the same format, each component the low
// 32 bits of its quotient, truncated toward zero. The squared length is the
// sum of the three squares, each shifted right by FracBits; when it is zero
// the result is the zero vector with was_zero_o set. One vector is in flight
// at a time, and the next beat is taken the cycle after the result is
// registered. The square root settles one bit a cycle, RootSteps = (64 -
// FracBits + 1) / 2 bits in all, and three restoring dividers run side by
// side, one quotient bit a cycle over a DivW = 32 + FracBits bit dividend.
// The result waits in an output register, so the input may take a new
// vector while the previous result is still held there.
module fixed_point_vec3_normalize (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] unit_x_o,
  output logic signed [31:0] unit_y_o,
  output logic signed [31:0] unit_z_o,
  output logic               was_zero_o
);
  import fpvn_pkg::*;

  fpvn_cmd_t cmd;
  fpvn_sts_t sts;

  // Sequence the squares, root, divisions and result load
  fpvn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the vector, the arithmetic and the output register
  fpvn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .unit_x_o    (unit_x_o),
    .unit_y_o    (unit_y_o),
    .unit_z_o    (unit_z_o),
    .was_zero_o  (was_zero_o)
  );

  // A vector just taken keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after a beat was taken");

  // The dividers only ever run against a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step || cmd.div_init |-> !sts.sum_zero)
    else $error("division started with a zero length");

  // A zero-length result carries the zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_zero_o |-> unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0)
    else $error("zero-length result with nonzero components");

endmodule

### verif/fpvn_checker.sv
module fpvn_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [fpvn_pkg::CompW-1:0] vec_x_i,
  input  logic signed [fpvn_pkg::CompW-1:0] vec_y_i,
  input  logic signed [fpvn_pkg::CompW-1:0] vec_z_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [fpvn_pkg::CompW-1:0] unit_x_i,
  input  logic signed [fpvn_pkg::CompW-1:0] unit_y_i,
  input  logic signed [fpvn_pkg::CompW-1:0] unit_z_i,
  input  logic                             was_zero_i,
  output int                               pending_o,
  output int                               mismatches_o,
  output int                               checked_o,
  output int                               zeros_o
);
  import fpvn_pkg::*;

  typedef struct packed {
    logic [CompW-1:0] ux;
    logic [CompW-1:0] uy;
    logic [CompW-1:0] uz;
    logic             was_zero;
  } unit_vec_t;

  unit_vec_t expected_units[$];

  function automatic unit_vec_t normalise_vec(input logic signed [CompW-1:0] x,
                                              input logic signed [CompW-1:0] y,
                                              input logic signed [CompW-1:0] z);
    logic signed [63:0] comp[NumComp];
    logic        [63:0] sumsq;
    logic        [63:0] rem;
    logic        [63:0] acc;
    logic        [63:0] probe;
    logic signed [63:0] len;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    logic [CompW-1:0]   unit[NumComp];
    unit_vec_t          res;
    comp[0] = x;
    comp[1] = y;
    comp[2] = z;
    sumsq = '0;
    for (int i = 0; i < NumComp; i++) begin
      sumsq = sumsq + ($unsigned(comp[i] * comp[i]) >> FracBits);
    end
    if (sumsq == 0) begin
      res = '{ux: '0, uy: '0, uz: '0, was_zero: 1'b1};
      return res;
    end
    // bit-by-bit root, one result bit per pair of probe bits
    acc   = '0;
    rem   = sumsq;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    len = $signed(acc << HalfFrac);
    for (int i = 0; i < NumComp; i++) begin
      num     = comp[i] <<< FracBits;
      quo     = num / len;
      unit[i] = quo[CompW-1:0];
    end
    res = '{ux: unit[0], uy: unit[1], uz: unit[2], was_zero: 1'b0};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    unit_vec_t want;
    int        errs;
    int        seen;
    int        zhits;
    if (!rst_ni) begin
      expected_units.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
      zeros_o      <= 0;
    end else begin
      errs  = 0;
      seen  = 0;
      zhits = 0;
      // check the result beat first, so a vector taken on this edge cannot match it
      if (out_valid_i && out_ready_i) begin
        if (expected_units.size() == 0) begin
          $error("result beat with no vector outstanding");
          errs++;
        end else begin
          want = expected_units.pop_front();
          seen = 1;
          zhits = want.was_zero;
          if (unit_x_i !== want.ux) begin
            $error("unit_x: expected %0d, got %0d", $signed(want.ux), unit_x_i);
            errs++;
          end
          if (unit_y_i !== want.uy) begin
            $error("unit_y: expected %0d, got %0d", $signed(want.uy), unit_y_i);
            errs++;
          end
          if (unit_z_i !== want.uz) begin
            $error("unit_z: expected %0d, got %0d", $signed(want.uz), unit_z_i);
            errs++;
          end
          if (was_zero_i !== want.was_zero) begin
            $error("was_zero: expected %0d, got %0d", want.was_zero, was_zero_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_units.push_back(normalise_vec(vec_x_i, vec_y_i, vec_z_i));
      end
      pending_o    <= expected_units.size();
      mismatches_o <= mismatches_o + errs;
      checked_o    <= checked_o + seen;
      zeros_o      <= zeros_o + zhits;
    end
  end

endmodule

### verif/tb.sv
module tb;
  import fpvn_pkg::*;

  // Run length and pacing
  localparam int          NumDirected   = 20;
  localparam int          NumRandom     = 550;
  localparam int          HoldOffCycles = 400;
  localparam int          DrainCycles   = 120;
  localparam int unsigned CycleLimit    = 400000;

  // Ways of drawing one component for the random part
  typedef enum int unsigned {
    KindFull,
    KindTiny,
    KindScaled,
    KindCorner
  } comp_kind_e;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [CompW-1:0] vec_x     = '0;
  logic signed [CompW-1:0] vec_y     = '0;
  logic signed [CompW-1:0] vec_z     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [CompW-1:0] unit_x;
  logic signed [CompW-1:0] unit_y;
  logic signed [CompW-1:0] unit_z;
  logic                    was_zero;

  int          pending;
  int          mismatches;
  int          checked;
  int          zero_hits;
  int          sent       = 0;
  int          hold_asked = 0;
  int unsigned cycles     = 0;
  // set while both sides must run flat out, with no idling at all
  bit          calm       = 1'b0;

  always #1 clk = ~clk;

  fixed_point_vec3_normalize dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .vec_z_i     (vec_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .unit_x_o    (unit_x),
    .unit_y_o    (unit_y),
    .unit_z_o    (unit_z),
    .was_zero_o  (was_zero)
  );

  fpvn_checker norm_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .unit_x_i     (unit_x),
    .unit_y_i     (unit_y),
    .unit_z_i     (unit_z),
    .was_zero_i   (was_zero),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .checked_o    (checked),
    .zeros_o      (zero_hits)
  );

  // Watchdog: end the run if the block hangs somewhere
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("fixed_point_vec3_normalize regression: fail");
      $finish;
    end
  end

  // Result side: drop ready at random, or hold it low for a long stretch on
  // request so that the output register fills and the input stalls behind it
  initial begin : result_sink
    int hold_left;
    int hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Present one vector beat and hold it until the block takes it. Called at a
  // rising edge; returns at the edge the beat was accepted. Valid is only
  // lowered when an idle gap goes in, so it never drops and rises in one step.
  task automatic offer_vec(input logic [CompW-1:0] x, input logic [CompW-1:0] y,
                           input logic [CompW-1:0] z);
    int gap;
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      // mostly short gaps, now and then one long enough to land anywhere in
      // the root or divide phases
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x    <= x;
    vec_y    <= y;
    vec_z    <= z;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Stop offering and wait until every result beat has been checked
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [CompW-1:0] pick_comp(input comp_kind_e kind);
    logic [CompW-1:0] v;
    case (kind)
      KindFull:   v = $urandom();
      // squares of these truncate to zero or to a handful of units
      KindTiny:   v = $urandom_range(0, 600);
      KindScaled: v = $urandom() >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 7))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'h7fff_ffff;
          3:       v = 32'h8000_0000;
          4:       v = 32'h0000_0100;
          5:       v = 32'h0001_0000;
          6:       v = 32'h0000_00ff;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    if (kind != KindFull && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic comp_kind_e pick_kind;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return KindFull;
    if (roll < 50) return KindTiny;
    if (roll < 85) return KindScaled;
    return KindCorner;
  endfunction

  initial begin : vec_source
    comp_kind_e kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero vector, squares that truncate away, the
    // smallest nonzero root, unit axes, full-scale extremes and
    // truncation toward zero on negative quotients
    offer_vec(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vec(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
    offer_vec(32'd181, -32'sd181, 32'd181);
    offer_vec(32'd255, 32'd0, 32'd0);
    offer_vec(32'd256, 32'd0, 32'd0);
    offer_vec(-32'sd256, 32'd0, 32'd0);
    offer_vec(32'h0001_0000, 32'd0, 32'd0);
    offer_vec(32'd0, -32'sh0001_0000, 32'd0);
    offer_vec(32'd0, 32'd0, 32'h0001_0000);
    offer_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    offer_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    offer_vec(32'h7fff_ffff, 32'd0, 32'd0);
    offer_vec(32'h8000_0000, 32'd0, 32'd0);
    offer_vec(-32'sh0003_0000, 32'h0004_0000, 32'd0);
    offer_vec(32'd1, 32'h7fff_ffff, 32'hffff_ffff);
    offer_vec(32'd300, 32'd300, 32'd300);
    offer_vec(-32'sd1000, 32'd1, 32'd0);
    offer_vec(32'd12345, -32'sd67890, 32'd2222222);
    offer_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    wait_drained();

    for (int k = 0; k < NumRandom; k++) begin
      // idle-free stretch
      if (k == 100) calm = 1'b1;
      if (k == 180) calm = 1'b0;
      // long receiver hold-off while the sender keeps offering
      if (k == 250) hold_asked++;
      // pause the sender until every result is home
      if (k == 400) wait_drained();
      if ($urandom_range(99) < 30) begin
        offer_vec(pick_comp(pick_kind()), pick_comp(pick_kind()), pick_comp(pick_kind()));
      end else begin
        kind = pick_kind();
        offer_vec(pick_comp(kind), pick_comp(kind), pick_comp(kind));
      end
    end

    wait_drained();
    // let any stray beat surface before the verdict
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d vectors (%0d directed, %0d random); checked %0d results, %0d zero length.",
             sent, NumDirected, NumRandom, checked, zero_hits);
    $display("Run took in a long output hold-off with input back-pressure, a full drain ",
             "pause and an idle-free stretch.");
    if (mismatches == 0 && pending == 0) begin
      $display("fixed_point_vec3_normalize regression: pass");
    end else begin
      $display("fixed_point_vec3_normalize regression: fail");
    end
    $finish;
  end

endmodule
